[design/cpo_pkg.sv]
`default_nettype none

package cpo_pkg;

  // Datapath widths.
  localparam int PHASE_BITS      = 32;
  localparam int TABLE_ADDR_BITS = 10;
  localparam int SINE_BITS       = 16;
  localparam int CONTROL_BITS    = 12;

  localparam int GAIN_W = 21;
  localparam int INC_W  = 32;
  localparam int MID_W  = 15;
  localparam int WAVE_W = 16;

  // Product and sum widths of the increment calculation.
  localparam int MULT_W = GAIN_W + CONTROL_BITS;
  localparam int SUM_W  = ((MULT_W > INC_W) ? MULT_W : INC_W) + 1;

  // Phase accumulator add width, wide enough for the sign-extended increment.
  localparam int PADD_W = (PHASE_BITS > INC_W) ? PHASE_BITS : INC_W;

  // Quarter-wave table: entries 0 to TAB_N inclusive, unsigned magnitudes.
  localparam int TAB_N     = 1 << TABLE_ADDR_BITS;
  localparam int ROM_W     = SINE_BITS - 1;
  localparam int SINE_AMP  = (1 << (SINE_BITS - 1)) - 1;
  localparam int SINE_HALF = SINE_AMP / 2;
  localparam int PROD_W    = MID_W + ROM_W;
  localparam int ROUND_W   = PROD_W + 1;
  localparam int QUOT_W    = ROUND_W - ROM_W;
  localparam int REM_W     = ((ROM_W > QUOT_W) ? ROM_W : QUOT_W) + 1;

  // Decoupling queue between the front and back parts.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  // Configuration port.
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [1:0] REG_GAIN = 2'd0;
  localparam logic [1:0] REG_BASE = 2'd1;
  localparam logic [1:0] REG_MID  = 2'd2;

  localparam logic [MID_W-1:0] MID_RESET = MID_W'(16384);

  // Half pi as an unsigned Q62 fraction.
  localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;

  typedef struct packed {
    logic signed [GAIN_W-1:0] gain_increment;
    logic signed [INC_W-1:0]  base_increment;
    logic        [MID_W-1:0]  mid_level;
  } cfg_t;

  typedef logic [ROM_W-1:0] sine_rom_t [0:TAB_N];

  // Rounded Q62 product: bits 125 down to 62 of a*b + 2^61.
  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = p + (128'd1 << 61);
    return p[125:62];
  endfunction

  // Unsigned quotient by restoring shift and subtract, used only to build the table.
  function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rmd;
    int          b;
    quo = '0;
    rmd = '0;
    for (b = 63; b >= 0; b--) begin
      rmd = {rmd[63:0], num[b]};
      if (rmd >= {1'b0, den}) begin
        rmd    = rmd - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Builds the quarter-wave sine table from a Taylor series in Q62.
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   rom;
    logic [63:0] step_hi;
    logic [63:0] step_lo;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] entry;
    logic [63:0] denom;
    int          i;
    int          k;
    step_hi = HALF_PI_Q62 >> TABLE_ADDR_BITS;
    step_lo = HALF_PI_Q62 & 64'(TAB_N - 1);
    for (i = 0; i <= TAB_N; i++) begin
      x    = step_hi * 64'(i) + ((step_lo * 64'(i)) >> TABLE_ADDR_BITS);
      x2   = mul_q62(x, x);
      term = x;
      sum  = x;
      for (k = 1; k <= 13; k++) begin
        denom = 64'((2 * k) * (2 * k + 1));
        term  = div_u64(mul_q62(term, x2), denom);
        if ((k % 2) == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      entry  = mul_q62(64'(SINE_AMP), sum);
      rom[i] = entry[ROM_W-1:0];
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

`default_nettype wire

[design/cpo_front.sv]
`default_nettype none

module cpo_front
  import cpo_pkg::*;
(
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire cfg_t                           cfg,
  input  wire logic signed [CONTROL_BITS-1:0] control,
  input  wire logic                           control_valid,
  output logic                                control_stall,
  input  wire logic                           queue_full,
  output logic                                push,
  output logic signed [INC_W-1:0]             push_inc
);

  localparam logic signed [INC_W-1:0] INC_MAX = {1'b0, {(INC_W-1){1'b1}}};
  localparam logic signed [INC_W-1:0] INC_MIN = {1'b1, {(INC_W-1){1'b0}}};

  logic                           held;
  logic signed [CONTROL_BITS-1:0] ctrl;
  logic                           accept;
  logic signed [MULT_W-1:0]       gain_prod;
  logic signed [SUM_W-1:0]        inc_sum;

  // The held request leaves when the queue has room.
  assign push          = held && !queue_full;
  assign control_stall = held && queue_full;
  assign accept        = control_valid && !control_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (accept) begin
      held <= 1'b1;
    end else if (push) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ctrl <= control;
    end
  end

  // Increment is base plus gain times control, clamped to the signed word range.
  always_comb begin
    gain_prod = cfg.gain_increment * ctrl;
    inc_sum   = SUM_W'(cfg.base_increment) + SUM_W'(gain_prod);
    if (inc_sum > SUM_W'(INC_MAX)) begin
      push_inc = INC_MAX;
    end else if (inc_sum < SUM_W'(INC_MIN)) begin
      push_inc = INC_MIN;
    end else begin
      push_inc = inc_sum[INC_W-1:0];
    end
  end

endmodule

`default_nettype wire

[design/cpo_queue.sv]
`default_nettype none

module cpo_queue
  import cpo_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    push,
  input  wire logic signed [INC_W-1:0] push_inc,
  output logic                         full,
  input  wire logic                    pop,
  output logic                         empty,
  output logic signed [INC_W-1:0]      pop_inc
);

  logic signed [INC_W-1:0] entries [0:QUEUE_DEPTH-1];
  logic [QPTR_W-1:0]       wr_ptr;
  logic [QPTR_W-1:0]       rd_ptr;
  logic [QCNT_W-1:0]       count;

  assign full    = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign pop_inc = entries[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_inc;
    end
  end

endmodule

`default_nettype wire

[design/cpo_back.sv]
`default_nettype none

module cpo_back
  import cpo_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire cfg_t                    cfg,
  input  wire logic                    queue_empty,
  input  wire logic signed [INC_W-1:0] pop_inc,
  output logic                         pop,
  output logic [WAVE_W-1:0]            wave,
  output logic signed [INC_W-1:0]      increment,
  output logic                         result_valid,
  input  wire logic                    result_stall
);

  logic                      advance;
  logic                      started;
  logic [PHASE_BITS-1:0]     phase;
  logic signed [PADD_W-1:0]  inc_wide;
  logic [PADD_W-1:0]         phase_sum;

  logic                      s1_valid;
  logic signed [INC_W-1:0]   s1_inc;
  logic [1:0]                quad;
  logic [TABLE_ADDR_BITS-1:0] tab_addr;
  logic [TABLE_ADDR_BITS:0]  rom_idx;

  logic                      s2_valid;
  logic [ROM_W-1:0]          s2_sine;
  logic                      s2_neg;
  logic signed [INC_W-1:0]   s2_inc;

  logic                      s3_valid;
  logic [PROD_W-1:0]         s3_prod;
  logic                      s3_neg;
  logic signed [INC_W-1:0]   s3_inc;

  logic [ROUND_W-1:0]        rounded;
  logic [QUOT_W-1:0]         quot;
  logic [REM_W-1:0]          rem;
  logic [WAVE_W-1:0]         mag;
  logic [WAVE_W-1:0]         mid_ext;
  logic [WAVE_W-1:0]         wave_next;

  // The whole back pipeline holds while a finished result waits.
  assign advance = !(result_valid && result_stall);
  assign pop     = !queue_empty && advance;

  // Phase accumulator; the first request after reset does not advance it.
  assign inc_wide  = PADD_W'(pop_inc);
  assign phase_sum = PADD_W'(phase) + inc_wide;

  always_ff @(posedge clk) begin
    if (rst) begin
      started      <= 1'b0;
      phase        <= '0;
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      s3_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else if (advance) begin
      s1_valid     <= pop;
      s2_valid     <= s1_valid;
      s3_valid     <= s2_valid;
      result_valid <= s3_valid;
      if (pop) begin
        started <= 1'b1;
        if (started) begin
          phase <= phase_sum[PHASE_BITS-1:0];
        end
      end
    end
  end

  // Quadrant folding onto the quarter-wave table.
  always_comb begin
    quad     = phase[PHASE_BITS-1 -: 2];
    tab_addr = phase[PHASE_BITS-3 -: TABLE_ADDR_BITS];
    if (quad[0]) begin
      rom_idx = (TABLE_ADDR_BITS+1)'(TAB_N) - {1'b0, tab_addr};
    end else begin
      rom_idx = {1'b0, tab_addr};
    end
  end

  // Scale by mid_level / SINE_AMP with rounding; the remainder stays below
  // twice the divisor, so one conditional correction suffices.
  always_comb begin
    rounded   = ROUND_W'(s3_prod) + ROUND_W'(SINE_HALF);
    quot      = rounded[ROUND_W-1:ROM_W];
    rem       = REM_W'(rounded[ROM_W-1:0]) + REM_W'(quot);
    mag       = WAVE_W'(quot) + WAVE_W'(rem >= REM_W'(SINE_AMP));
    mid_ext   = WAVE_W'(cfg.mid_level);
    wave_next = s3_neg ? (mid_ext - mag) : (mid_ext + mag);
  end

  // Table read, multiply and output registers.
  always_ff @(posedge clk) begin
    if (advance) begin
      if (pop) begin
        s1_inc <= pop_inc;
      end
      s2_sine   <= SINE_ROM[rom_idx];
      s2_neg    <= quad[1];
      s2_inc    <= s1_inc;
      s3_prod   <= PROD_W'(cfg.mid_level) * PROD_W'(s2_sine);
      s3_neg    <= s2_neg;
      s3_inc    <= s2_inc;
      wave      <= wave_next;
      increment <= s3_inc;
    end
  end

endmodule

`default_nettype wire

[design/controlled_phase_oscillator.sv]
// Throughput: one request per cycle while result_stall does not hold the output;
// the phase accumulator add is the only loop, and the table read and amplitude
// multiply are pipelined behind it.
// Reset (synchronous, active high) clears the phase, the pipeline and queue,
// and sets gain and base increments to zero and mid_level to 16384.
`default_nettype none

module controlled_phase_oscillator
  import cpo_pkg::*;
(
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [ADDR_W-1:0]              paddr,
  input  wire logic [DATA_W-1:0]              pwdata,
  output logic [DATA_W-1:0]                   prdata,
  output logic                                pready,
  input  wire logic signed [CONTROL_BITS-1:0] control,
  input  wire logic                           control_valid,
  output logic                                control_stall,
  output logic [WAVE_W-1:0]                   wave,
  output logic signed [INC_W-1:0]             increment,
  output logic                                result_valid,
  input  wire logic                           result_stall
);

  cfg_t                    cfg;
  logic                    cfg_write;
  logic [1:0]              reg_index;
  logic                    q_push;
  logic                    q_full;
  logic                    q_pop;
  logic                    q_empty;
  logic signed [INC_W-1:0] push_inc;
  logic signed [INC_W-1:0] pop_inc;

  // Configuration registers.
  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_increment <= '0;
      cfg.base_increment <= '0;
      cfg.mid_level      <= MID_RESET;
    end else if (cfg_write) begin
      case (reg_index)
        REG_GAIN: cfg.gain_increment <= pwdata[GAIN_W-1:0];
        REG_BASE: cfg.base_increment <= pwdata[INC_W-1:0];
        REG_MID:  cfg.mid_level      <= pwdata[MID_W-1:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_GAIN: prdata = DATA_W'(unsigned'(cfg.gain_increment));
      REG_BASE: prdata = DATA_W'(unsigned'(cfg.base_increment));
      REG_MID:  prdata = DATA_W'(cfg.mid_level);
      default:  prdata = '0;
    endcase
  end

  cpo_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .control       (control),
    .control_valid (control_valid),
    .control_stall (control_stall),
    .queue_full    (q_full),
    .push          (q_push),
    .push_inc      (push_inc)
  );

  cpo_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_inc (push_inc),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .pop_inc  (pop_inc)
  );

  cpo_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .queue_empty  (q_empty),
    .pop_inc      (pop_inc),
    .pop          (q_pop),
    .wave         (wave),
    .increment    (increment),
    .result_valid (result_valid),
    .result_stall (result_stall)
  );

  // Reset leaves no result pending and the front ready.
  assert property (@(posedge clk) $past(rst) |-> (!result_valid && !control_stall))
    else $error("pipeline not cleared by reset");

  // A request pushed into the queue is visible to the back part next cycle.
  assert property (@(posedge clk) disable iff (rst) q_push |=> !q_empty)
    else $error("queue lost a pushed request");

  // A full queue cannot also report empty.
  assert property (@(posedge clk) disable iff (rst) q_full |-> !q_empty)
    else $error("queue fill count inconsistent");

endmodule

`default_nettype wire

[sim/cpo_checker.sv]
// Watches the request and result channels and the register port of the oscillator,
// predicts every sample and compares it with what the block produces.
module cpo_checker
  import cpo_pkg::*;
(
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic                           pready,
  input  wire logic [ADDR_W-1:0]              paddr,
  input  wire logic [DATA_W-1:0]              pwdata,
  input  wire logic signed [CONTROL_BITS-1:0] control,
  input  wire logic                           control_valid,
  input  wire logic                           control_stall,
  input  wire logic [WAVE_W-1:0]              wave,
  input  wire logic signed [INC_W-1:0]        increment,
  input  wire logic                           result_valid,
  input  wire logic                           result_stall,
  output int                                  mismatches,
  output int                                  outstanding
);

  typedef struct packed {
    logic [WAVE_W-1:0]       wave;
    logic signed [INC_W-1:0] increment;
  } sample_t;

  localparam int     REPORT_LIMIT = 100;
  localparam longint INC_MAX      = 64'sd2147483647;
  localparam longint INC_MIN      = -64'sd2147483647 - 64'sd1;

  // Quarter-wave sine magnitudes, entries 0 to TAB_N inclusive.
  logic [63:0] quarter_sine [0:TAB_N];

  // Shadow copy of the registers and of the oscillator state.
  logic signed [GAIN_W-1:0] gain_reg;
  logic signed [INC_W-1:0]  base_reg;
  logic [MID_W-1:0]         mid_reg;
  logic [PHASE_BITS-1:0]    phase_acc;
  logic                     started;

  // Samples predicted for accepted requests, oldest first.
  sample_t expected_samples [$];

  // Unsigned Q62 product, rounded to nearest.
  function automatic logic [63:0] q62_product(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] full;
    full = 128'(a) * 128'(b) + (128'd1 << 61);
    return full[125:62];
  endfunction

  // One table entry: Taylor series of sin(x) in Q62, then scaled to the amplitude.
  function automatic logic [63:0] sine_entry(input int idx);
    logic [63:0] step_whole;
    logic [63:0] step_frac;
    logic [63:0] x;
    logic [63:0] x_sq;
    logic [63:0] term;
    logic [63:0] acc;
    step_whole = HALF_PI_Q62 >> TABLE_ADDR_BITS;
    step_frac  = HALF_PI_Q62 & 64'(TAB_N - 1);
    x          = step_whole * 64'(idx) + ((step_frac * 64'(idx)) >> TABLE_ADDR_BITS);
    x_sq       = q62_product(x, x);
    term       = x;
    acc        = x;
    for (int k = 1; k <= 13; k++) begin
      term = q62_product(term, x_sq) / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    return q62_product(64'(SINE_AMP), acc);
  endfunction

  initial begin
    for (int i = 0; i <= TAB_N; i++) begin
      quarter_sine[i] = sine_entry(i);
    end
  end

  // Advances the phase for one request and works out the sample it gives.
  function automatic sample_t next_sample(input logic signed [CONTROL_BITS-1:0] ctrl);
    sample_t     res;
    longint      step;
    longint      level;
    longint      mag;
    logic [1:0]  quad;
    int          addr;
    step = longint'(base_reg) + longint'(gain_reg) * longint'(ctrl);
    if (step > INC_MAX) begin
      step = INC_MAX;
    end else if (step < INC_MIN) begin
      step = INC_MIN;
    end
    // The first request after reset leaves the phase where it is.
    if (started) begin
      phase_acc = phase_acc + PHASE_BITS'(step);
    end
    started = 1'b1;
    quad = phase_acc[PHASE_BITS-1 -: 2];
    addr = int'(phase_acc[PHASE_BITS-3 -: TABLE_ADDR_BITS]);
    if (quad[0]) begin
      addr = TAB_N - addr;
    end
    level = longint'(mid_reg);
    mag   = (level * longint'(quarter_sine[addr]) + longint'(SINE_AMP / 2))
            / longint'(SINE_AMP);
    res.wave      = WAVE_W'(quad[1] ? level - mag : level + mag);
    res.increment = INC_W'(step);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      $display("%0t: %s: expected %h, got %h", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    sample_t want;
    if (rst) begin
      gain_reg  = '0;
      base_reg  = '0;
      mid_reg   = MID_RESET;
      phase_acc = '0;
      started   = 1'b0;
      expected_samples.delete();
    end else begin
      // Register writes; an index with no register behind it is ignored.
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_GAIN: gain_reg = pwdata[GAIN_W-1:0];
          REG_BASE: base_reg = pwdata[INC_W-1:0];
          REG_MID:  mid_reg  = pwdata[MID_W-1:0];
          default: ;
        endcase
      end
      // Each accepted request adds one expected sample.
      if (control_valid && !control_stall) begin
        expected_samples.push_back(next_sample(control));
      end
      // Each accepted result is checked against the oldest prediction.
      if (result_valid && !result_stall) begin
        if (expected_samples.size() == 0) begin
          report_mismatch("result with nothing expected", '0, 64'({wave, increment}));
        end else begin
          want = expected_samples.pop_front();
          if (wave !== want.wave) begin
            report_mismatch("wave", 64'(want.wave), 64'(wave));
          end
          if (increment !== want.increment) begin
            report_mismatch("increment", 64'(want.increment), 64'(increment));
          end
        end
      end
    end
    outstanding <= expected_samples.size();
  end

endmodule

[sim/controlled_phase_oscillator_test.sv]
module controlled_phase_oscillator_test;
  import cpo_pkg::*;

  localparam int         QUIET_LIMIT     = 2000;
  localparam int         HOLD_CYCLES     = 120;
  localparam int         PHASES          = 8;
  localparam int         ITEMS_PER_PHASE = 153;
  localparam int         DRAIN_CYCLES    = 10;
  localparam logic [1:0] REG_SPARE       = 2'd3;

  logic                           clk           = 1'b0;
  logic                           rst           = 1'b1;
  logic                           psel          = 1'b0;
  logic                           penable       = 1'b0;
  logic                           pwrite        = 1'b0;
  logic [ADDR_W-1:0]              paddr         = '0;
  logic [DATA_W-1:0]              pwdata        = '0;
  logic signed [CONTROL_BITS-1:0] control       = '0;
  logic                           control_valid = 1'b0;
  logic                           result_stall  = 1'b0;

  logic [DATA_W-1:0]       prdata;
  logic                    pready;
  logic                    control_stall;
  logic [WAVE_W-1:0]       wave;
  logic signed [INC_W-1:0] increment;
  logic                    result_valid;

  int mismatches;
  int outstanding;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_asked    = 0;
  int hold_done     = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;

  always #5 clk = ~clk;

  controlled_phase_oscillator dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .control       (control),
    .control_valid (control_valid),
    .control_stall (control_stall),
    .wave          (wave),
    .increment     (increment),
    .result_valid  (result_valid),
    .result_stall  (result_stall)
  );

  cpo_checker sample_check (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .control       (control),
    .control_valid (control_valid),
    .control_stall (control_stall),
    .wave          (wave),
    .increment     (increment),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .mismatches    (mismatches),
    .outstanding   (outstanding)
  );

  // Result side: a long hold-off when asked for, otherwise random stalls.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      result_stall <= 1'b1;
      hold_left    <= hold_left - 1;
    end else if (hold_asked != hold_done) begin
      result_stall <= 1'b1;
      hold_left    <= HOLD_CYCLES;
      hold_done    <= hold_done + 1;
    end else begin
      result_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Watchdog: ends the run when nothing has moved for too long.
  always @(posedge clk) begin
    if (rst || (control_valid && !control_stall) || (result_valid && !result_stall) ||
        (psel && penable && pwrite && pready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Register write: setup cycle, access cycle, then the port is left idle.
  task automatic write_reg(input logic [1:0] index, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({index, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Offers one control request, after a random gap, and waits until it is taken.
  task automatic send_control(input logic signed [CONTROL_BITS-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      control_valid <= 1'b0;
      @(posedge clk);
    end
    control       <= value;
    control_valid <= 1'b1;
    @(posedge clk);
    while (control_stall) @(posedge clk);
  endtask

  // Stops offering requests and waits for every predicted sample to come out.
  task automatic drain();
    control_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [CONTROL_BITS-1:0] random_control();
    case ($urandom_range(9))
      0:       return -12'sd2048;
      1:       return 12'sd2047;
      default: return CONTROL_BITS'($urandom);
    endcase
  endfunction

  // New random settings; the unused upper data bits carry random junk.
  task automatic random_settings();
    logic [GAIN_W-1:0] gain;
    logic [INC_W-1:0]  base;
    logic [MID_W-1:0]  mid;
    case ($urandom_range(3))
      0:       gain = $urandom_range(1) ? GAIN_W'(1048575) : GAIN_W'(-1048576);
      1:       gain = GAIN_W'(int'($urandom_range(8191)) - 4096);
      default: gain = GAIN_W'($urandom);
    endcase
    case ($urandom_range(3))
      0:       base = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: base = $urandom;
    endcase
    case ($urandom_range(3))
      0:       mid = $urandom_range(1) ? MID_W'(0) : MID_W'(32767);
      default: mid = MID_W'($urandom_range(32767));
    endcase
    write_reg(REG_GAIN, {(DATA_W - GAIN_W)'($urandom), gain});
    write_reg(REG_BASE, base);
    write_reg(REG_MID, {(DATA_W - MID_W)'($urandom), mid});
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Registers at their reset values; the first request does not advance.
    send_control(12'sd0);
    send_control(12'sd2047);
    send_control(-12'sd2048);
    drain();

    // Largest gain and base: full positive control saturates upwards.
    write_reg(REG_GAIN, 32'd1048575);
    write_reg(REG_BASE, 32'h7FFF_FFFF);
    write_reg(REG_MID, 32'd32767);
    write_reg(REG_SPARE, 32'hDEAD_BEEF);
    send_control(12'sd2047);
    send_control(-12'sd2048);
    send_control(12'sd0);
    send_control(12'sd1);
    send_control(-12'sd1);
    drain();

    // Most negative gain and base: saturates downwards, zero amplitude.
    write_reg(REG_GAIN, 32'h001F_FFFF & 32'h0010_0000);
    write_reg(REG_BASE, 32'h8000_0000);
    write_reg(REG_MID, 32'd0);
    send_control(12'sd2047);
    send_control(-12'sd2048);
    send_control(-12'sd1);
    drain();

    // Values with junk above the register widths; increments of both signs.
    write_reg(REG_GAIN, 32'hFFE0_0400);
    write_reg(REG_BASE, 32'hFFFF_FFFF);
    write_reg(REG_MID, 32'hFFFF_FFFF);
    send_control(12'sd2047);
    send_control(12'sd1000);
    send_control(-12'sd1);
    send_control(-12'sd2048);
    send_control(12'sd0);
    drain();

    // Quarter-turn steps land on each quadrant boundary, including the top entry.
    write_reg(REG_GAIN, 32'd0);
    write_reg(REG_BASE, 32'h4000_0000);
    write_reg(REG_MID, 32'd20000);
    repeat (5) send_control(12'sd0);
    drain();

    // Random phases: each starts from new settings written while the block is idle.
    for (int p = 0; p < PHASES; p++) begin
      if (p < 3) begin
        send_idle_pct = 25;
        recv_idle_pct = 54;
      end else if (p < 6) begin
        send_idle_pct = 54;
        recv_idle_pct = 25;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      random_settings();
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Hold the result side off so that the block fills and stalls its input.
        if ((p == 1 || p == 4) && n == 20) begin
          hold_asked++;
        end
        send_control(random_control());
      end
      drain();
    end

    if (mismatches == 0 && outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[filelist.f]
design/cpo_pkg.sv
design/cpo_front.sv
design/cpo_queue.sv
design/cpo_back.sv
design/controlled_phase_oscillator.sv
sim/cpo_checker.sv
sim/controlled_phase_oscillator_test.sv
